>>> sv/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and codes for the i2c memory transfer sequencer: command kinds,
// engine actions, error codes, bus status values and the queue entry type.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    // default width of the remaining byte counter
    localparam int LENGTH_BITS_DEFAULT = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input command codes
    localparam logic [1:0] CMD_BEGIN_READ  = 2'd0;
    localparam logic [1:0] CMD_BEGIN_WRITE = 2'd1;
    localparam logic [1:0] CMD_ENGINE_DONE = 2'd2;

    // classified transaction kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_READ  = 2'd0;
    localparam kind_t KIND_WRITE = 2'd1;
    localparam kind_t KIND_DONE  = 2'd2;
    localparam kind_t KIND_NONE  = 2'd3;

    // engine actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_RXACK   = 3'd3;
    localparam logic [2:0] ACT_RXNAK   = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;
    localparam logic [2:0] ACT_RESTART = 3'd6;

    // error codes
    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_START      = 3'd1;
    localparam logic [2:0] ERR_ADDR_NACK  = 3'd2;
    localparam logic [2:0] ERR_WRITE_NACK = 3'd3;
    localparam logic [2:0] ERR_RXACK      = 3'd4;
    localparam logic [2:0] ERR_RXNAK      = 3'd5;

    // bus engine status values
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REPSTART  = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_DATAW_ACK = 8'h28;
    localparam logic [7:0] ST_DATAR_ACK = 8'h50;
    localparam logic [7:0] ST_DATAR_NAK = 8'h58;
    localparam logic [7:0] ST_MASK      = 8'hf8;

    // one classified transaction as it travels from front to back
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  device_address;
        logic [7:0]  memory_address;
        logic [15:0] transfer_length;
        logic [7:0]  status_code;
        logic [7:0]  bus_data;
        logic [7:0]  write_data;
    } entry_t;

endpackage

>>> sv/i2cmts_front.sv
// ----------------------------------------------------------------------------
// i2cmts_front
// Input stage: takes transactions, classifies the command and masks the
// engine status, then hands the entry to the queue.
// ----------------------------------------------------------------------------
module i2cmts_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [7:0]         s_device_address,
    input  logic [7:0]         s_memory_address,
    input  logic [15:0]        s_transfer_length,
    input  logic [7:0]         s_status_code,
    input  logic [7:0]         s_bus_data,
    input  logic [7:0]         s_write_data,
    output logic               q_valid,
    input  logic               q_ready,
    output i2cmts_pkg::entry_t q_entry
);

    logic               ent_valid_reg;
    logic               ent_valid_next;
    i2cmts_pkg::entry_t ent_reg;
    i2cmts_pkg::entry_t ent_next;
    i2cmts_pkg::kind_t  kind;

    assign s_ready = !ent_valid_reg || q_ready;
    assign q_valid = ent_valid_reg;
    assign q_entry = ent_reg;

    // command classification
    always_comb begin
        unique case (s_command)
            i2cmts_pkg::CMD_BEGIN_READ:  kind = i2cmts_pkg::KIND_READ;
            i2cmts_pkg::CMD_BEGIN_WRITE: kind = i2cmts_pkg::KIND_WRITE;
            i2cmts_pkg::CMD_ENGINE_DONE: kind = i2cmts_pkg::KIND_DONE;
            default:                     kind = i2cmts_pkg::KIND_NONE;
        endcase
    end

    // next entry and occupancy
    always_comb begin
        ent_next                 = ent_reg;
        ent_valid_next           = ent_valid_reg;
        if (ent_valid_reg && q_ready) begin
            ent_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            ent_valid_next           = 1'b1;
            ent_next.kind            = kind;
            ent_next.device_address  = s_device_address;
            ent_next.memory_address  = s_memory_address;
            ent_next.transfer_length = s_transfer_length;
            ent_next.status_code     = s_status_code & i2cmts_pkg::ST_MASK;
            ent_next.bus_data        = s_bus_data;
            ent_next.write_data      = s_write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= 1'b0;
        end else begin
            ent_valid_reg <= ent_valid_next;
        end
        ent_reg <= ent_next;
    end

endmodule

>>> sv/i2cmts_queue.sv
// ----------------------------------------------------------------------------
// i2cmts_queue
// Short first-in first-out queue of classified transactions between the
// front and the back.
// ----------------------------------------------------------------------------
module i2cmts_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  i2cmts_pkg::entry_t in_entry,
    output logic               out_valid,
    input  logic               out_ready,
    output i2cmts_pkg::entry_t out_entry
);

    localparam int DEPTH    = i2cmts_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    i2cmts_pkg::entry_t  mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != CNT_BITS'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

>>> sv/i2cmts_back.sv
// ----------------------------------------------------------------------------
// i2cmts_back
// Transfer sequencer: steps through the phases of a memory read or write,
// one queued transaction a cycle unless stalled; result in an output register.
// ----------------------------------------------------------------------------
module i2cmts_back #(
    parameter int LENGTH_BITS = i2cmts_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  i2cmts_pkg::entry_t q_entry,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_engine_action,
    output logic [7:0]         m_send_byte,
    output logic               m_took_write_data,
    output logic [7:0]         m_read_byte,
    output logic               m_read_valid,
    output logic               m_finished,
    output logic [2:0]         m_error_code
);

    localparam int EXT_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    // phase codes
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_START   = 4'd1;
    localparam logic [3:0] PH_SLAW    = 4'd2;
    localparam logic [3:0] PH_MEM     = 4'd3;
    localparam logic [3:0] PH_DATA    = 4'd4;
    localparam logic [3:0] PH_RESTART = 4'd5;
    localparam logic [3:0] PH_SLAR    = 4'd6;
    localparam logic [3:0] PH_RXACK   = 4'd7;
    localparam logic [3:0] PH_RXNAK   = 4'd8;

    logic [3:0]             phase_reg,     phase_next;
    logic                   is_read_reg,   is_read_next;
    logic [7:0]             dev_reg,       dev_next;
    logic [7:0]             loc_reg,       loc_next;
    logic [LENGTH_BITS-1:0] left_reg,      left_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             act_reg,       act_next;
    logic [7:0]             send_reg,      send_next;
    logic                   took_reg,      took_next;
    logic [7:0]             rbyte_reg,     rbyte_next;
    logic                   rvalid_reg,    rvalid_next;
    logic                   fin_reg,       fin_next;
    logic [2:0]             err_reg,       err_next;

    logic [EXT_BITS-1:0]    len_ext;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [7:0]             st;
    logic                   start_ok;
    logic                   step;

    assign q_ready = !out_valid_reg || m_ready;
    assign step    = q_valid && q_ready;

    assign len_ext  = EXT_BITS'(q_entry.transfer_length);
    assign len      = len_ext[LENGTH_BITS-1:0];
    assign left_dec = left_reg - 1'b1;
    assign st       = q_entry.status_code;
    assign start_ok = (st == i2cmts_pkg::ST_START) || (st == i2cmts_pkg::ST_REPSTART);

    // phase sequencing and result for one transaction
    always_comb begin
        phase_next     = phase_reg;
        is_read_next   = is_read_reg;
        dev_next       = dev_reg;
        loc_next       = loc_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !m_ready;
        act_next       = act_reg;
        send_next      = send_reg;
        took_next      = took_reg;
        rbyte_next     = rbyte_reg;
        rvalid_next    = rvalid_reg;
        fin_next       = fin_reg;
        err_next       = err_reg;

        if (step) begin
            out_valid_next = 1'b1;
            act_next       = i2cmts_pkg::ACT_NONE;
            send_next      = 8'h00;
            took_next      = 1'b0;
            rbyte_next     = 8'h00;
            rvalid_next    = 1'b0;
            fin_next       = 1'b0;
            err_next       = i2cmts_pkg::ERR_OK;

            unique case (q_entry.kind)
                i2cmts_pkg::KIND_READ, i2cmts_pkg::KIND_WRITE: begin
                    is_read_next  = (q_entry.kind == i2cmts_pkg::KIND_READ);
                    dev_next      = q_entry.device_address;
                    loc_next      = q_entry.memory_address;
                    left_next     = len;
                    // a zero-length read moves one byte
                    if ((q_entry.kind == i2cmts_pkg::KIND_READ) && (len == '0)) begin
                        left_next = LENGTH_BITS'(1);
                    end
                    act_next   = i2cmts_pkg::ACT_START;
                    phase_next = PH_START;
                end
                i2cmts_pkg::KIND_DONE: begin
                    unique case (phase_reg)
                        PH_START: begin
                            if (!start_ok) begin
                                fin_next = 1'b1; err_next = i2cmts_pkg::ERR_START;
                                phase_next = PH_IDLE;
                            end else begin
                                act_next   = i2cmts_pkg::ACT_SEND;
                                send_next  = dev_reg;
                                phase_next = PH_SLAW;
                            end
                        end
                        PH_SLAW: begin
                            if (st != i2cmts_pkg::ST_SLAW_ACK) begin
                                fin_next = 1'b1; err_next = i2cmts_pkg::ERR_ADDR_NACK;
                                phase_next = PH_IDLE;
                            end else begin
                                act_next   = i2cmts_pkg::ACT_SEND;
                                send_next  = loc_reg;
                                phase_next = PH_MEM;
                            end
                        end
                        PH_MEM, PH_DATA: begin
                            if (st != i2cmts_pkg::ST_DATAW_ACK) begin
                                fin_next = 1'b1; err_next = i2cmts_pkg::ERR_WRITE_NACK;
                                phase_next = PH_IDLE;
                            end else if (is_read_reg && (phase_reg == PH_MEM)) begin
                                act_next   = i2cmts_pkg::ACT_RESTART;
                                phase_next = PH_RESTART;
                            end else if (left_reg == '0) begin
                                act_next   = i2cmts_pkg::ACT_STOP;
                                fin_next   = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                act_next   = i2cmts_pkg::ACT_SEND;
                                send_next  = q_entry.write_data;
                                took_next  = 1'b1;
                                left_next  = left_dec;
                                phase_next = PH_DATA;
                            end
                        end
                        PH_RESTART: begin
                            if (!start_ok) begin
                                fin_next = 1'b1; err_next = i2cmts_pkg::ERR_START;
                                phase_next = PH_IDLE;
                            end else begin
                                act_next   = i2cmts_pkg::ACT_SEND;
                                send_next  = dev_reg | 8'h01;
                                phase_next = PH_SLAR;
                            end
                        end
                        PH_SLAR: begin
                            if (st != i2cmts_pkg::ST_SLAR_ACK) begin
                                fin_next = 1'b1; err_next = i2cmts_pkg::ERR_ADDR_NACK;
                                phase_next = PH_IDLE;
                            end else if (left_reg > LENGTH_BITS'(1)) begin
                                act_next   = i2cmts_pkg::ACT_RXACK;
                                phase_next = PH_RXACK;
                            end else begin
                                act_next   = i2cmts_pkg::ACT_RXNAK;
                                phase_next = PH_RXNAK;
                            end
                        end
                        PH_RXACK: begin
                            if (st != i2cmts_pkg::ST_DATAR_ACK) begin
                                fin_next = 1'b1; err_next = i2cmts_pkg::ERR_RXACK;
                                phase_next = PH_IDLE;
                            end else begin
                                rbyte_next  = q_entry.bus_data;
                                rvalid_next = 1'b1;
                                left_next   = left_dec;
                                if (left_dec > LENGTH_BITS'(1)) begin
                                    act_next   = i2cmts_pkg::ACT_RXACK;
                                    phase_next = PH_RXACK;
                                end else begin
                                    act_next   = i2cmts_pkg::ACT_RXNAK;
                                    phase_next = PH_RXNAK;
                                end
                            end
                        end
                        PH_RXNAK: begin
                            if (st != i2cmts_pkg::ST_DATAR_NAK) begin
                                fin_next = 1'b1; err_next = i2cmts_pkg::ERR_RXNAK;
                                phase_next = PH_IDLE;
                            end else begin
                                act_next    = i2cmts_pkg::ACT_STOP;
                                rbyte_next  = q_entry.bus_data;
                                rvalid_next = 1'b1;
                                fin_next    = 1'b1;
                                phase_next  = PH_IDLE;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                    // unknown command: all-zero result, state kept
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            is_read_reg   <= 1'b0;
            dev_reg       <= 8'h00;
            loc_reg       <= 8'h00;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            is_read_reg   <= is_read_next;
            dev_reg       <= dev_next;
            loc_reg       <= loc_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        send_reg   <= send_next;
        took_reg   <= took_next;
        rbyte_reg  <= rbyte_next;
        rvalid_reg <= rvalid_next;
        fin_reg    <= fin_next;
        err_reg    <= err_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_engine_action   = act_reg;
    assign m_send_byte       = send_reg;
    assign m_took_write_data = took_reg;
    assign m_read_byte       = rbyte_reg;
    assign m_read_valid      = rvalid_reg;
    assign m_finished        = fin_reg;
    assign m_error_code      = err_reg;

endmodule

>>> sv/i2c_memory_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_memory_transfer_sequencer
// Drives a byte-level i2c bus engine through a memory read or write: each
// transaction in yields one transaction out naming the next engine action.
// ----------------------------------------------------------------------------
//  channel | direction | ports | content
//  --------+-----------+-------+------------------------------------------
//  input   | in        | s_*   | begin read/write or engine-done event
//  result  | out       | m_*   | engine action, bytes, finish and error
//
//  One transaction per cycle sustained while m_ready is high; the result
//  passes through the front register, the queue and the result register.
//  The back's phase register is updated once per transaction, which sets
//  the rate at one decision per cycle while the result is taken.
//  Synchronous active-low reset returns to idle with empty queue.
//  A stall on m_ready fills the result register, then the queue, then the
//  front register before s_ready drops.
// ----------------------------------------------------------------------------
module i2c_memory_transfer_sequencer #(
    parameter int LENGTH_BITS = i2cmts_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_device_address,
    input  logic [7:0]  s_memory_address,
    input  logic [15:0] s_transfer_length,
    input  logic [7:0]  s_status_code,
    input  logic [7:0]  s_bus_data,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_engine_action,
    output logic [7:0]  m_send_byte,
    output logic        m_took_write_data,
    output logic [7:0]  m_read_byte,
    output logic        m_read_valid,
    output logic        m_finished,
    output logic [2:0]  m_error_code
);

    logic               f_valid;
    logic               f_ready;
    i2cmts_pkg::entry_t f_entry;
    logic               b_valid;
    logic               b_ready;
    i2cmts_pkg::entry_t b_entry;

    // classify incoming transactions
    i2cmts_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_device_address  (s_device_address),
        .s_memory_address  (s_memory_address),
        .s_transfer_length (s_transfer_length),
        .s_status_code     (s_status_code),
        .s_bus_data        (s_bus_data),
        .s_write_data      (s_write_data),
        .q_valid           (f_valid),
        .q_ready           (f_ready),
        .q_entry           (f_entry)
    );

    // decouple front and back
    i2cmts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_entry  (f_entry),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_entry (b_entry)
    );

    // sequence the transfer
    i2cmts_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (b_valid),
        .q_ready           (b_ready),
        .q_entry           (b_entry),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_engine_action   (m_engine_action),
        .m_send_byte       (m_send_byte),
        .m_took_write_data (m_took_write_data),
        .m_read_byte       (m_read_byte),
        .m_read_valid      (m_read_valid),
        .m_finished        (m_finished),
        .m_error_code      (m_error_code)
    );

endmodule

>>> sv/i2cmts_checker.sv
// ----------------------------------------------------------------------------
// i2cmts_checker
// Port-level checks on the result channel of the sequencer, attached by bind.
// ----------------------------------------------------------------------------
module i2cmts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_engine_action,
    input logic [7:0] m_send_byte,
    input logic       m_took_write_data,
    input logic       m_finished,
    input logic [2:0] m_error_code
);

    // an error code only comes with the end of a transfer
    a_err_needs_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_finished) |-> (m_error_code == i2cmts_pkg::ERR_OK))
        else $error("error code without finish");

    // an error exit asks the engine for nothing
    a_err_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error_code != i2cmts_pkg::ERR_OK))
        |-> (m_engine_action == i2cmts_pkg::ACT_NONE))
        else $error("action issued on error exit");

    // write data and nonzero send bytes only go with a send action
    a_send_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_took_write_data || (m_send_byte != 8'h00)))
        |-> (m_engine_action == i2cmts_pkg::ACT_SEND))
        else $error("send byte without send action");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_engine_action)
        && $stable(m_send_byte) && $stable(m_error_code)))
        else $error("stalled result changed");

endmodule

bind i2c_memory_transfer_sequencer i2cmts_checker u_i2cmts_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_engine_action   (m_engine_action),
    .m_send_byte       (m_send_byte),
    .m_took_write_data (m_took_write_data),
    .m_finished        (m_finished),
    .m_error_code      (m_error_code)
);
